### hdl/npk_pkg.sv
package npk_pkg;

  localparam int STORE_BYTES = 4096;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int CAP_BITS    = STORE_BYTES * 8;
  localparam int POS_W       = $clog2(CAP_BITS + 1);
  localparam int USED_W      = POS_W - 3;

  typedef enum logic [1:0] {
    OP_WRITE        = 2'd0,
    OP_READ         = 2'd1,
    OP_REWIND_READ  = 2'd2,
    OP_REWIND_WRITE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // bit offsets inside the addressed store byte for the writer and the reader
  typedef struct packed {
    logic [2:0] wr_sh;
    logic [2:0] rd_sh;
  } align_ctl_t;

endpackage

### hdl/nine_bit_continuation_packer.sv
// Bit-packed byte store of STORE_BYTES bytes. Every byte is kept as nine bits, LSB first: eight
// data bits and a continuation bit that is 0 on the last byte of a block. Each request yields one
// result carrying status and the used byte count. A write passes S_IDLE and S_W2, a read S_IDLE,
// S_R1 and S_R2, a rewind only S_IDLE; the single read port of the store RAM sets these steps,
// since a nine-bit field spans two store bytes. A write merges into the byte at the write
// position and overwrites the next one. Writes past capacity report full, reads past the write
// position report empty; both leave the state unchanged. The store needs no clearing: reads
// never reach unwritten bits. No new request is taken while a result waits to be taken.
module nine_bit_continuation_packer
  import npk_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        operation_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_in_block_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        read_byte_o,
  output logic              block_end_o,
  output logic [1:0]        status_o,
  output logic [USED_W-1:0] used_bytes_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_W2   = 2'd1;
  localparam logic [1:0] S_R1   = 2'd2;
  localparam logic [1:0] S_R2   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [POS_W-1:0] wp_q, wp_d;
  logic [POS_W-1:0] rp_q, rp_d;
  logic [8:0]       val_q, val_d;
  logic [7:0]       lo_q, lo_d;

  logic              out_valid_q;
  logic [7:0]        read_byte_q;
  logic              block_end_q;
  status_e           status_q;
  logic [USED_W-1:0] used_q;

  logic        out_free, in_acc, full, empty, fin;
  op_e         op;
  logic [POS_W:0] wr_sum, rd_sum;
  logic [ADDR_W-1:0] wr_idx, rd_idx;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  align_ctl_t  actl;
  logic [8:0]  wr_val;
  logic [7:0]  wr_lo, wr_hi, rd_byte;
  logic        rd_end;

  logic [7:0]        res_byte;
  logic              res_end;
  status_e           res_st;
  logic [USED_W:0]   used_sum;
  logic [USED_W-1:0] used_next;

  npk_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign actl.wr_sh = wp_q[2:0];
  assign actl.rd_sh = rp_q[2:0];
  assign wr_val = (state_q == S_IDLE) ? {~last_in_block_i, data_byte_i} : val_q;

  npk_align u_align (
    .ctl_i     (actl),
    .wr_val_i  (wr_val),
    .old_lo_i  (ram_rdata),
    .rd_pair_i ({ram_rdata, lo_q}),
    .wr_lo_o   (wr_lo),
    .wr_hi_o   (wr_hi),
    .rd_byte_o (rd_byte),
    .rd_end_o  (rd_end)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign op         = op_e'(operation_i);

  assign wr_sum = {1'b0, wp_q} + (POS_W+1)'(9);
  assign rd_sum = {1'b0, rp_q} + (POS_W+1)'(9);
  assign full   = wr_sum > (POS_W+1)'(CAP_BITS);
  assign empty  = rd_sum > {1'b0, wp_q};
  assign wr_idx = wp_q[ADDR_W+2:3];
  assign rd_idx = rp_q[ADDR_W+2:3];

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    val_d     = val_q;
    lo_d      = lo_q;
    ram_we    = 1'b0;
    ram_waddr = wr_idx;
    ram_wdata = wr_lo;
    ram_re    = 1'b0;
    ram_raddr = rd_idx;
    fin       = 1'b0;
    res_byte  = 8'd0;
    res_end   = 1'b0;
    res_st    = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (op)
            OP_WRITE: begin
              if (full) begin
                fin    = 1'b1;
                res_st = ST_FULL;
              end else begin
                // write the upper byte now, fetch the lower one for the merge
                ram_we    = 1'b1;
                ram_waddr = wr_idx + ADDR_W'(1);
                ram_wdata = wr_hi;
                ram_re    = 1'b1;
                ram_raddr = wr_idx;
                val_d     = wr_val;
                state_d   = S_W2;
              end
            end
            OP_READ: begin
              if (empty) begin
                fin    = 1'b1;
                res_st = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = rd_idx;
                state_d   = S_R1;
              end
            end
            OP_REWIND_READ: begin
              rp_d = '0;
              fin  = 1'b1;
            end
            OP_REWIND_WRITE: begin
              wp_d = '0;
              fin  = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_W2: begin
        if (out_free) begin
          ram_we    = 1'b1;
          ram_waddr = wr_idx;
          ram_wdata = wr_lo;
          wp_d      = POS_W'(wp_q + POS_W'(9));
          fin       = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_R1: begin
        ram_re    = 1'b1;
        ram_raddr = rd_idx + ADDR_W'(1);
        lo_d      = ram_rdata;
        state_d   = S_R2;
      end
      S_R2: begin
        if (out_free) begin
          res_byte = rd_byte;
          res_end  = rd_end;
          rp_d     = POS_W'(rp_q + POS_W'(9));
          fin      = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // store bytes from byte 0 through the one holding the write position, 0 at position 0, saturated at capacity
  always_comb begin
    used_sum = {1'b0, wp_d[POS_W-1:3]} + (USED_W+1)'(1);
    if (wp_d == '0) begin
      used_next = '0;
    end else if (used_sum > (USED_W+1)'(STORE_BYTES)) begin
      used_next = USED_W'(STORE_BYTES);
    end else begin
      used_next = used_sum[USED_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    lo_q  <= lo_d;
    if (fin) begin
      read_byte_q <= res_byte;
      block_end_q <= res_end;
      status_q    <= res_st;
      used_q      <= used_next;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_byte_o  = read_byte_q;
  assign block_end_o  = block_end_q;
  assign status_o     = status_q;
  assign used_bytes_o = used_q;

  a_wp_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, wp_q} <= (POS_W+1)'(CAP_BITS))
    else $error("write position beyond capacity");

  a_w2_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_W2) && out_free |=> out_valid_o && (status_o == ST_OK) && !block_end_o)
    else $error("write did not complete with ok result");

  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (read_byte_o == 8'd0) && !block_end_o)
    else $error("refused request returned data");

  a_rd_lead : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_R1) || (state_q == S_R2) |-> rd_sum <= {1'b0, wp_q})
    else $error("read in progress past write position");

endmodule

### hdl/npk_ram.sv
module npk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold the last read word while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/npk_align.sv
module npk_align
  import npk_pkg::*;
(
  input  align_ctl_t  ctl_i,
  input  logic [8:0]  wr_val_i,
  input  logic [7:0]  old_lo_i,
  input  logic [15:0] rd_pair_i,
  output logic [7:0]  wr_lo_o,
  output logic [7:0]  wr_hi_o,
  output logic [7:0]  rd_byte_o,
  output logic        rd_end_o
);

  logic [15:0] wr_word;
  logic [7:0]  keep_mask;
  logic [15:0] rd_word;

  always_comb begin
    wr_word   = {7'd0, wr_val_i} << ctl_i.wr_sh;
    // keep the bits below the write position, replace the rest
    keep_mask = (8'd1 << ctl_i.wr_sh) - 8'd1;
    wr_lo_o   = (old_lo_i & keep_mask) | wr_word[7:0];
    wr_hi_o   = wr_word[15:8];

    rd_word   = rd_pair_i >> ctl_i.rd_sh;
    rd_byte_o = rd_word[7:0];
    rd_end_o  = ~rd_word[8];
  end

endmodule
